/* src/vwd_pkg.sv */
`default_nettype none
package vwd_pkg;

  localparam int TABLE_SLOTS  = 8192;
  localparam int SLOT_W       = $clog2(TABLE_SLOTS);
  localparam int MAX_VERTICES = 4096;
  localparam int CNT_W        = $clog2(MAX_VERTICES) + 1;
  localparam int IDX_W        = 12;

  localparam logic [63:0] GOLDEN   = 64'h9E3779B97F4A7C15;
  localparam logic [63:0] NEG_ZERO = 64'h8000000000000000;

  // one table slot as stored in memory
  typedef struct packed {
    logic             used;
    logic [IDX_W-1:0] vert;
    logic [63:0]      kz;
    logic [63:0]      ky;
    logic [63:0]      kx;
  } slot_t;

  localparam int SLOT_BITS = $bits(slot_t);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_HASH,
    ST_READ,
    ST_CHECK
  } state_t;

  typedef enum logic [2:0] {
    HS_MUL0,
    HS_MUL1,
    HS_MUL2,
    HS_SUM,
    HS_MIXY,
    HS_MIXZ
  } hstep_t;

endpackage
`default_nettype wire

/* src/vwd_ram.sv */
`default_nettype none
module vwd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write, or read with registered data
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule
`default_nettype wire

/* src/vwd_hash.sv */
`default_nettype none
module vwd_hash (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [63:0] kx,
  input  wire logic [63:0] ky,
  input  wire logic [63:0] kz,
  output logic      [63:0] hash,
  output logic             done
);

  logic           run;
  vwd_pkg::hstep_t step;
  logic [31:0]    ma;
  logic [31:0]    mb;
  logic [63:0]    prod;
  logic [63:0]    acc;
  logic [63:0]    mix_add;
  logic [63:0]    mix_in;

  // pick operands of the shared 32x32 multiplier
  always_comb begin
    case (step)
      vwd_pkg::HS_MUL0: begin ma = kx[31:0];  mb = vwd_pkg::GOLDEN[31:0];  end
      vwd_pkg::HS_MUL1: begin ma = kx[63:32]; mb = vwd_pkg::GOLDEN[31:0];  end
      vwd_pkg::HS_MUL2: begin ma = kx[31:0];  mb = vwd_pkg::GOLDEN[63:32]; end
      default:          begin ma = kx[31:0];  mb = vwd_pkg::GOLDEN[31:0];  end
    endcase
  end

  // one mix round: w + GOLDEN + (h << 6) + (h >> 2)
  assign mix_in  = (step == vwd_pkg::HS_MIXY) ? ky : kz;
  assign mix_add = mix_in + vwd_pkg::GOLDEN + {hash[57:0], 6'd0} + {2'd0, hash[63:2]};

  // advance one step per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      step <= vwd_pkg::HS_MUL0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run  <= 1'b1;
        step <= vwd_pkg::HS_MUL0;
      end else if (run) begin
        case (step)
          vwd_pkg::HS_MUL0: step <= vwd_pkg::HS_MUL1;
          vwd_pkg::HS_MUL1: step <= vwd_pkg::HS_MUL2;
          vwd_pkg::HS_MUL2: step <= vwd_pkg::HS_SUM;
          vwd_pkg::HS_SUM:  step <= vwd_pkg::HS_MIXY;
          vwd_pkg::HS_MIXY: step <= vwd_pkg::HS_MIXZ;
          default: begin
            run  <= 1'b0;
            done <= 1'b1;
          end
        endcase
      end
    end
  end

  // multiply, accumulate and mix datapath
  always_ff @(posedge clk) begin
    prod <= ma * mb;
    case (step)
      vwd_pkg::HS_MUL1: acc  <= prod;
      vwd_pkg::HS_MUL2: acc  <= acc + {prod[31:0], 32'd0};
      vwd_pkg::HS_SUM:  hash <= acc + {prod[31:0], 32'd0};
      vwd_pkg::HS_MIXY: hash <= hash ^ mix_add;
      vwd_pkg::HS_MIXZ: hash <= hash ^ mix_add;
      default: ;
    endcase
  end

endmodule
`default_nettype wire

/* src/vertex_weld_dedup.sv */
`default_nettype none
// From start, the key is hashed in 6 steps on the shared 32x32 multiplier; then the
// home slot is read from the single-port slot memory (registered read) and checked;
// each further probe repeats the read and the check before result_valid is registered.
// busy is high until the result cycle and no new item is taken while it is; results never stall.
// Reset, and every item marked last_corner, starts a clearing pass over all 8192
// slots of the slot memory, during which busy stays high.
module vertex_weld_dedup (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [63:0] x_bits,
  input  wire logic [63:0] y_bits,
  input  wire logic [63:0] z_bits,
  input  wire logic        last_corner,
  output logic             result_valid,
  output logic [11:0]      vertex_index,
  output logic             is_new,
  output logic             overflow,
  output logic             done_res
);

  vwd_pkg::state_t state, state_next;
  logic [63:0]                 kx, ky, kz;
  logic                        last;
  logic [vwd_pkg::SLOT_W-1:0]  pos;
  logic [vwd_pkg::SLOT_W-1:0]  nprobe;
  logic [vwd_pkg::SLOT_W-1:0]  clr;
  logic [vwd_pkg::CNT_W-1:0]   vcount;
  logic                        accept;
  logic [63:0]                 hash;
  logic                        hash_done;
  vwd_pkg::slot_t              rd_slot, wr_slot;
  logic                        ram_we;
  logic [vwd_pkg::SLOT_W-1:0]  ram_addr;
  logic                        hit, room, settle;

  assign accept = start && !busy;
  assign busy   = (state != vwd_pkg::ST_IDLE);

  // hash the held key over the following cycles
  vwd_hash u_hash (
    .clk   (clk),
    .rst   (rst),
    .start (accept),
    .kx    (kx),
    .ky    (ky),
    .kz    (kz),
    .hash  (hash),
    .done  (hash_done)
  );

  vwd_ram #(
    .WIDTH (vwd_pkg::SLOT_BITS),
    .DEPTH (vwd_pkg::TABLE_SLOTS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (wr_slot),
    .rdata (rd_slot)
  );

  assign hit    = rd_slot.used && rd_slot.kx == kx && rd_slot.ky == ky && rd_slot.kz == kz;
  assign room   = (vcount < vwd_pkg::CNT_W'(vwd_pkg::MAX_VERTICES));
  assign settle = !rd_slot.used || hit ||
                  (nprobe == vwd_pkg::SLOT_W'(vwd_pkg::TABLE_SLOTS - 1));

  // next state and memory controls
  always_comb begin
    state_next   = state;
    ram_we       = 1'b0;
    ram_addr     = pos;
    wr_slot.used = 1'b1;
    wr_slot.vert = vcount[vwd_pkg::IDX_W-1:0];
    wr_slot.kx   = kx;
    wr_slot.ky   = ky;
    wr_slot.kz   = kz;
    case (state)
      vwd_pkg::ST_CLEAR: begin
        ram_we       = 1'b1;
        ram_addr     = clr;
        wr_slot.used = 1'b0;
        if (clr == vwd_pkg::SLOT_W'(vwd_pkg::TABLE_SLOTS - 1)) begin
          state_next = vwd_pkg::ST_IDLE;
        end
      end
      vwd_pkg::ST_IDLE: begin
        if (accept) state_next = vwd_pkg::ST_HASH;
      end
      vwd_pkg::ST_HASH: begin
        if (hash_done) state_next = vwd_pkg::ST_READ;
      end
      vwd_pkg::ST_READ: state_next = vwd_pkg::ST_CHECK;
      vwd_pkg::ST_CHECK: begin
        if (!rd_slot.used && room) ram_we = 1'b1;
        if (settle) begin
          state_next = last ? vwd_pkg::ST_CLEAR : vwd_pkg::ST_IDLE;
        end else begin
          state_next = vwd_pkg::ST_READ;
        end
      end
      default: state_next = vwd_pkg::ST_IDLE;
    endcase
  end

  // state and control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= vwd_pkg::ST_CLEAR;
      clr          <= '0;
      vcount       <= '0;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      result_valid <= 1'b0;
      if (state == vwd_pkg::ST_CLEAR) clr <= clr + 1'b1;
      if (state == vwd_pkg::ST_CHECK && settle) begin
        result_valid <= 1'b1;
        clr          <= '0;
        if (last) begin
          vcount <= '0;
        end else if (!rd_slot.used && room) begin
          vcount <= vcount + 1'b1;
        end
      end
    end
  end

  // hold the key, walk the probe position, form the result
  always_ff @(posedge clk) begin
    if (accept) begin
      kx   <= (x_bits == vwd_pkg::NEG_ZERO) ? 64'd0 : x_bits;
      ky   <= (y_bits == vwd_pkg::NEG_ZERO) ? 64'd0 : y_bits;
      kz   <= (z_bits == vwd_pkg::NEG_ZERO) ? 64'd0 : z_bits;
      last <= last_corner;
    end
    if (state == vwd_pkg::ST_HASH && hash_done) begin
      pos    <= hash[vwd_pkg::SLOT_W-1:0];
      nprobe <= '0;
    end
    if (state == vwd_pkg::ST_CHECK) begin
      if (settle) begin
        done_res <= last;
        if (!rd_slot.used) begin
          vertex_index <= room ? vcount[vwd_pkg::IDX_W-1:0] : '0;
          is_new       <= room;
          overflow     <= !room;
        end else if (hit) begin
          vertex_index <= rd_slot.vert;
          is_new       <= 1'b0;
          overflow     <= 1'b0;
        end else begin
          vertex_index <= '0;
          is_new       <= 1'b0;
          overflow     <= 1'b1;
        end
      end else begin
        pos    <= pos + 1'b1;
        nprobe <= nprobe + 1'b1;
      end
    end
  end

endmodule
`default_nettype wire
